### hw/rtl/ctq_pkg.sv
// Shared constants, types and codes of the connection timeout queue.
package ctq_pkg;

  localparam int unsigned CAPACITY  = 32;
  localparam int unsigned CONN_BITS = 10;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 10;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 6;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [CONN_BITS-1:0] conn_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [SEQ_W-1:0]     seq_t;
  typedef logic [CNT_W-1:0]     count_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_EXPIRED = 2'd1,
    ST_NONE    = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAIT = 1'd0,
    CFG_KICK = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_MARK   = 2'd3
  } cell_op_e;

  // Contents of one timer slot; mark flags entries due in the running tick.
  typedef struct packed {
    time_t expiry;
    conn_t conn;
    seq_t  seq;
    logic  mark;
  } cell_data_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_op_e op;
    time_t    key;
    conn_t    conn;
    seq_t     seq;
    logic     pop;
  } cell_ctl_t;

endpackage

### hw/rtl/ctq_req_if.sv
// Request channel of the connection timeout queue.
interface ctq_req_if import ctq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [ID_W-1:0]     conn_id;
  logic [SEQ_W-1:0]    seq_num;
  logic [TIME_W-1:0]   now;

  modport source (output valid, cmd, conn_id, seq_num, now, input ready);
  modport sink   (input valid, cmd, conn_id, seq_num, now, output ready);
endinterface

### hw/rtl/ctq_rsp_if.sv
// Result channel of the connection timeout queue.
interface ctq_rsp_if import ctq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [ID_W-1:0]     out_conn;
  logic [SEQ_W-1:0]    out_seq;
  logic [TIME_W-1:0]   earliest;
  logic [OCC_W-1:0]    occupancy;
  logic                last;

  modport source (output valid, status, out_conn, out_seq, earliest, occupancy, last,
                  input ready);
  modport sink   (input valid, status, out_conn, out_seq, earliest, occupancy, last,
                  output ready);
endinterface

### hw/rtl/connection_timeout_queue_unit.sv
// Connection timeout queue: a row of CAPACITY timer cells sorted by expiry
// (ties in arrival order), driven by a small sequencer. Every request is
// accepted, executed and then has its result posted. Delete repeats its
// execute step once per removed entry, since each step closes the gap of the
// first matching cell. A tick marks the due entries in one step, then pops
// them one by one (with an extra insert pass for each entry when expired
// entries are re-armed); a tick with nothing due reports that none is due.
// A result waiting in the output register does not stop the next request
// from being taken. Configuration writes land at once.
module connection_timeout_queue_unit import ctq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ctq_req_if.sink              req_i,
  ctq_rsp_if.source            rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WAIT_W-1:0]    cfg_wdata_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_POP  = 5'b00100,
    S_INS  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  count_t  count_q, count_d;
  logic [WAIT_W-1:0] wait_q;
  logic    kick_q;

  cmd_e    cmd_q;
  time_t   key_q, now_q;
  conn_t   item_conn_q, item_conn_d;
  seq_t    item_seq_q, item_seq_d;
  status_e status_q, status_d;
  logic    last_q, last_d;

  logic    rsp_valid_q;
  logic [STAT_W-1:0] rsp_status_q;
  logic [ID_W-1:0]   rsp_conn_q;
  logic [SEQ_W-1:0]  rsp_seq_q;
  logic [TIME_W-1:0] rsp_earliest_q;
  logic [OCC_W-1:0]  rsp_occ_q;
  logic              rsp_last_q;

  cell_ctl_t  ctl;
  cell_data_t head;
  logic       second_mark, any_hit;
  logic       req_fire, rsp_load;
  logic [TIME_W:0] exp_sum;
  time_t      exp_sat;

  ctq_chain u_chain (
    .clk_i         (clk_i),
    .ctl_i         (ctl),
    .count_i       (count_q),
    .head_o        (head),
    .second_mark_o (second_mark),
    .any_hit_o     (any_hit)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // saturate the expiry at the top of the time range
  assign exp_sum = {1'b0, req_i.now} + {{(TIME_W + 1 - WAIT_W){1'b0}}, wait_q};
  assign exp_sat = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    item_conn_d = item_conn_q;
    item_seq_d  = item_seq_q;
    status_d    = status_q;
    last_d      = last_q;
    rsp_load    = 1'b0;
    ctl.op      = OP_NOP;
    ctl.key     = key_q;
    ctl.conn    = item_conn_q;
    ctl.seq     = item_seq_q;
    ctl.pop     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          item_conn_d = CONN_BITS'(req_i.conn_id);
          item_seq_d  = req_i.seq_num;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_q)
          CMD_ADD: begin
            last_d  = 1'b1;
            state_d = S_EMIT;
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_DONE;
              ctl.op   = OP_INSERT;
              count_d  = count_q + 1'b1;
            end
          end
          CMD_TICK: begin
            ctl.op  = OP_MARK;
            ctl.key = now_q;
            state_d = S_POP;
          end
          CMD_DELETE: begin
            // remove one match per cycle until none is left
            if (any_hit) begin
              ctl.op  = OP_REMOVE;
              count_d = count_q - 1'b1;
            end else begin
              status_d = ST_DONE;
              last_d   = 1'b1;
              state_d  = S_EMIT;
            end
          end
          CMD_CLEAR: begin
            count_d  = '0;
            status_d = ST_DONE;
            last_d   = 1'b1;
            state_d  = S_EMIT;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_POP: begin
        if (!head.mark) begin
          status_d = ST_NONE;
          last_d   = 1'b1;
          state_d  = S_EMIT;
        end else begin
          ctl.op      = OP_REMOVE;
          ctl.pop     = 1'b1;
          count_d     = count_q - 1'b1;
          item_conn_d = head.conn;
          item_seq_d  = head.seq;
          status_d    = ST_EXPIRED;
          last_d      = !second_mark;
          state_d     = kick_q ? S_EMIT : S_INS;
        end
      end
      S_INS: begin
        // re-arm the popped entry at now plus wait
        ctl.op  = OP_INSERT;
        count_d = count_q + 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = last_q ? S_IDLE : S_POP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wait_q      <= WAIT_W'(20);
      kick_q      <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WAIT: wait_q <= cfg_wdata_i;
          CFG_KICK: kick_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_conn_q <= item_conn_d;
    item_seq_q  <= item_seq_d;
    status_q    <= status_d;
    last_q      <= last_d;
    if (req_fire) begin
      cmd_q <= cmd_e'(req_i.cmd);
      now_q <= req_i.now;
      key_q <= exp_sat;
    end
    if (rsp_load) begin
      rsp_status_q   <= status_q;
      rsp_conn_q     <= (status_q == ST_EXPIRED) ? ID_W'(item_conn_q) : '0;
      rsp_seq_q      <= (status_q == ST_EXPIRED) ? item_seq_q : '0;
      rsp_earliest_q <= (count_q != '0) ? head.expiry : '0;
      rsp_occ_q      <= OCC_W'(count_q);
      rsp_last_q     <= last_q;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.out_conn  = rsp_conn_q;
  assign rsp_o.out_seq   = rsp_seq_q;
  assign rsp_o.earliest  = rsp_earliest_q;
  assign rsp_o.occupancy = rsp_occ_q;
  assign rsp_o.last      = rsp_last_q;

endmodule

### hw/rtl/ctq_cell.sv
// One timer slot of the sorted row: holds, loads, or takes a neighbor's entry.
module ctq_cell import ctq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctl_t  ctl_i,
  input  logic       valid_i,
  input  cell_data_t prev_i,
  input  logic       prev_keep_i,
  input  logic       prev_hit_i,
  input  cell_data_t next_i,
  output cell_data_t data_o,
  output logic       keep_o,
  output logic       hit_o
);

  cell_data_t data_q, data_d;

  always_comb begin
    keep_o = valid_i && (data_q.expiry <= ctl_i.key);
    hit_o  = prev_hit_i || (valid_i && (ctl_i.pop || (data_q.conn == ctl_i.conn)));
    data_d = data_q;
    case (ctl_i.op)
      OP_INSERT: begin
        // entries at or below the new expiry stay; the first slot after them loads
        if (!keep_o) begin
          if (prev_keep_i) begin
            data_d.expiry = ctl_i.key;
            data_d.conn   = ctl_i.conn;
            data_d.seq    = ctl_i.seq;
            data_d.mark   = 1'b0;
          end else begin
            data_d = prev_i;
          end
        end
      end
      OP_REMOVE: begin
        // close the gap left by the first hit
        if (hit_o) begin
          data_d = next_i;
        end
      end
      OP_MARK: begin
        data_d.mark = keep_o;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hw/rtl/ctq_chain.sv
// Row of timer cells kept in ascending expiry order.
module ctq_chain import ctq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctl_t  ctl_i,
  input  count_t     count_i,
  output cell_data_t head_o,
  output logic       second_mark_o,
  output logic       any_hit_o
);

  cell_data_t data [CAPACITY];
  logic       keep [CAPACITY];
  logic       hit  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_data_t prev_data, next_data;
    logic       prev_keep, prev_hit, valid;

    assign valid = CNT_W'(i) < count_i;

    if (i == 0) begin : g_first
      assign prev_data = '0;
      assign prev_keep = 1'b1;
      assign prev_hit  = 1'b0;
    end else begin : g_inner
      assign prev_data = data[i-1];
      assign prev_keep = keep[i-1];
      assign prev_hit  = hit[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_body
      assign next_data = data[i+1];
    end

    ctq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_i),
      .valid_i     (valid),
      .prev_i      (prev_data),
      .prev_keep_i (prev_keep),
      .prev_hit_i  (prev_hit),
      .next_i      (next_data),
      .data_o      (data[i]),
      .keep_o      (keep[i]),
      .hit_o       (hit[i])
    );
  end

  assign head_o        = data[0];
  assign second_mark_o = data[1].mark;
  assign any_hit_o     = hit[CAPACITY-1];

endmodule

### sim/ctq_checker.sv
`timescale 1ns / 1ps
// Checker of the connection timeout queue: predicts the timer table and compares every result.
module ctq_checker import ctq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ctq_req_if                   req_i,
  ctq_rsp_if                   rsp_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WAIT_W-1:0]    cfg_wdata_i,
  output int unsigned          errors_o,
  output int unsigned          outstanding_o,
  output int unsigned          checked_o
);

  typedef struct packed {
    time_t expiry;
    conn_t conn;
    seq_t  seq;
  } timer_t;

  typedef struct packed {
    status_e          status;
    conn_t            conn;
    seq_t             seq;
    time_t            earliest;
    logic [OCC_W-1:0] occupancy;
    logic             last;
  } reply_t;

  timer_t            timers[$];
  reply_t            queued_replies[$];
  logic [WAIT_W-1:0] wait_time = 16'd20;
  logic              kick      = 1'b1;
  int unsigned       mismatches   = 0;
  int unsigned       replies_seen = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic time_t expiry_for(time_t now);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + {{(TIME_W + 1 - WAIT_W){1'b0}}, wait_time};
    return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

  // Ties go behind existing entries of the same expiry.
  function automatic void insert_timer(timer_t t);
    int unsigned pos;
    pos = 0;
    while (pos < timers.size() && timers[pos].expiry <= t.expiry) pos++;
    timers.insert(pos, t);
  endfunction

  function automatic void post(status_e status, conn_t conn, seq_t seq, logic last);
    reply_t r;
    r.status    = status;
    r.conn      = conn;
    r.seq       = seq;
    r.earliest  = (timers.size() != 0) ? timers[0].expiry : '0;
    r.occupancy = OCC_W'(timers.size());
    r.last      = last;
    queued_replies = {queued_replies, r};
  endfunction

  function automatic void run_command(cmd_e cmd, conn_t conn, seq_t seq, time_t now);
    int unsigned due;
    int unsigned i;
    timer_t      t;
    case (cmd)
      CMD_ADD: begin
        if (timers.size() >= CAPACITY) begin
          post(ST_FULL, '0, '0, 1'b1);
        end else begin
          t.expiry = expiry_for(now);
          t.conn   = conn;
          t.seq    = seq;
          insert_timer(t);
          post(ST_DONE, '0, '0, 1'b1);
        end
      end
      CMD_TICK: begin
        // only entries due when the tick starts; re-armed ones wait for the next tick
        due = 0;
        while (due < timers.size() && timers[due].expiry <= now) due++;
        if (due == 0) begin
          post(ST_NONE, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < due; i++) begin
            t = timers[0];
            timers.delete(0);
            if (!kick) begin
              timer_t rearmed;
              rearmed        = t;
              rearmed.expiry = expiry_for(now);
              insert_timer(rearmed);
            end
            post(ST_EXPIRED, t.conn, t.seq, i + 1 == due);
          end
        end
      end
      CMD_DELETE: begin
        i = 0;
        while (i < timers.size()) begin
          if (timers[i].conn == conn) timers.delete(i);
          else i++;
        end
        post(ST_DONE, '0, '0, 1'b1);
      end
      CMD_CLEAR: begin
        timers.delete();
        post(ST_DONE, '0, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic compare_reply();
    reply_t want;
    replies_seen++;
    if (queued_replies.size() == 0) begin
      report_mismatch("result with no request pending", 64'(rsp_i.status), '0);
      return;
    end
    want = queued_replies[0];
    queued_replies.delete(0);
    if (rsp_i.status !== want.status)
      report_mismatch("status", 64'(rsp_i.status), 64'(want.status));
    if (rsp_i.out_conn !== want.conn)
      report_mismatch("out_conn", 64'(rsp_i.out_conn), 64'(want.conn));
    if (rsp_i.out_seq !== want.seq)
      report_mismatch("out_seq", 64'(rsp_i.out_seq), 64'(want.seq));
    if (rsp_i.earliest !== want.earliest)
      report_mismatch("earliest", 64'(rsp_i.earliest), 64'(want.earliest));
    if (rsp_i.occupancy !== want.occupancy)
      report_mismatch("occupancy", 64'(rsp_i.occupancy), 64'(want.occupancy));
    if (rsp_i.last !== want.last)
      report_mismatch("last", 64'(rsp_i.last), 64'(want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timers.delete();
      queued_replies.delete();
      wait_time = 16'd20;
      kick      = 1'b1;
      errors_o      <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WAIT: wait_time = cfg_wdata_i;
          CFG_KICK: kick = cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (req_i.valid && req_i.ready)
        run_command(cmd_e'(req_i.cmd), conn_t'(req_i.conn_id), req_i.seq_num, req_i.now);
      if (rsp_i.valid && rsp_i.ready) compare_reply();
      errors_o      <= mismatches;
      outstanding_o <= queued_replies.size();
      checked_o     <= replies_seen;
    end
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Top of the connection timeout queue testbench: clock, reset, requests, result stalls, verdict.
module tb;
  import ctq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned ROUND_ITEMS = 90;
  localparam int unsigned FILL_ITEMS  = CAPACITY + 4;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WAIT_W-1:0]    cfg_wdata;
  int unsigned          errors;
  int unsigned          outstanding;
  int unsigned          checked;

  ctq_req_if req ();
  ctq_rsp_if rsp ();

  connection_timeout_queue_unit i_dut (
    .clk_i,
    .rst_ni,
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  ctq_checker i_checker (
    .clk_i,
    .rst_ni,
    .req_i         (req),
    .rsp_i         (rsp),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  always #5 clk_i = ~clk_i;

  time_t             clock_now;
  logic [WAIT_W-1:0] wait_cur;
  bit                steady   = 1'b0;
  bit                hold_rsp = 1'b0;
  int unsigned       sent [4];

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("connection_timeout_queue_unit test failed");
    $finish;
  end

  // Result side: random stall per result, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    rsp.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      stall = steady ? 0 : $urandom_range(7);
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp.valid);
    end
  end

  task automatic issue(cmd_e cmd, conn_t conn, seq_t seq, time_t now);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(7);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.cmd     <= cmd;
    req.conn_id <= conn;
    req.seq_num <= seq;
    req.now     <= now;
    do @(posedge clk_i); while (!req.ready);
    sent[cmd]++;
  endtask

  // Drop valid and wait for every predicted result to come back.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [WAIT_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic configure(logic [WAIT_W-1:0] wait_val, logic kick_val);
    logic [WAIT_W-1:0] kick_word;
    kick_word    = WAIT_W'($urandom);
    kick_word[0] = kick_val;
    settle();
    set_reg(CFG_WAIT, wait_val);
    set_reg(CFG_KICK, kick_word);
    wait_cur = wait_val;
  endtask

  // Mostly a small pool of ids so that deletes hit and ids repeat.
  function automatic conn_t pick_conn();
    return ($urandom_range(3) == 0) ? conn_t'($urandom_range(1023)) : conn_t'($urandom_range(15));
  endfunction

  task automatic random_round(int unsigned count);
    int unsigned pick;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(24) == 0) steady = ~steady;
      pick = $urandom_range(99);
      if (pick < 46) begin
        issue(CMD_ADD, pick_conn(), seq_t'($urandom), clock_now);
      end else if (pick < 80) begin
        clock_now += $urandom_range(wait_cur / 2 + 1);
        issue(CMD_TICK, conn_t'($urandom_range(1023)), seq_t'($urandom), clock_now);
      end else if (pick < 92) begin
        issue(CMD_DELETE, pick_conn(), seq_t'($urandom), time_t'($urandom));
      end else if (pick < 95) begin
        issue(CMD_CLEAR, conn_t'($urandom_range(1023)), seq_t'($urandom), time_t'($urandom));
      end else begin
        // noise: any command with any field values
        issue(cmd_e'($urandom_range(3)), conn_t'($urandom_range(1023)), seq_t'($urandom),
              time_t'($urandom));
      end
    end
  endtask

  initial begin
    req.valid   <= 1'b0;
    req.cmd     <= CMD_ADD;
    req.conn_id <= '0;
    req.seq_num <= '0;
    req.now     <= '0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_WAIT;
    cfg_wdata   <= '0;
    wait_cur    = 16'd20;
    clock_now   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: wait 20, drop expired entries.
    issue(CMD_TICK, '0, '0, '0);
    issue(CMD_DELETE, conn_t'(77), '0, '0);
    issue(CMD_ADD, '0, '0, '0);
    issue(CMD_ADD, conn_t'(1023), '1, '1);
    issue(CMD_ADD, conn_t'(5), seq_t'(5), '0);
    issue(CMD_ADD, conn_t'(7), seq_t'(32'h5A5A_A5A5), time_t'(10));
    issue(CMD_TICK, '0, '0, time_t'(19));
    issue(CMD_TICK, '0, '0, time_t'(20));
    issue(CMD_DELETE, conn_t'(1023), '0, '0);
    issue(CMD_DELETE, conn_t'(999), '0, '0);
    issue(CMD_CLEAR, '0, '0, '0);

    // Longest wait, re-arm mode: saturated expiries must not pop twice in one tick.
    configure(16'hFFFF, 1'b0);
    issue(CMD_ADD, conn_t'(3), seq_t'(32'h1234_5678), '0);
    issue(CMD_ADD, conn_t'(4), seq_t'(32'h8765_4321), time_t'(32'hFFFF_FFF0));
    issue(CMD_ADD, conn_t'(3), seq_t'(32'hFFFF_0000), time_t'(5));
    issue(CMD_TICK, '0, '0, time_t'(70000));
    issue(CMD_TICK, '0, '0, '1);
    issue(CMD_TICK, '0, '0, '1);
    issue(CMD_DELETE, conn_t'(3), '0, '0);
    issue(CMD_CLEAR, '0, '0, '0);

    // Fill the table behind a stalled result side, overflow it, then pop everything.
    configure(16'd1, 1'b1);
    hold_rsp = 1'b1;
    for (int unsigned i = 0; i < FILL_ITEMS; i++)
      issue(CMD_ADD, conn_t'($urandom_range(7)), seq_t'($urandom), time_t'(100 + i / 3));
    settle();
    issue(CMD_TICK, '0, '0, '1);

    configure(16'd1, 1'b1);
    clock_now = time_t'($urandom_range(1000));
    random_round(ROUND_ITEMS);

    configure(16'hFFFF, 1'b0);
    clock_now = time_t'(32'hFFFB_0000);
    random_round(ROUND_ITEMS);

    configure(WAIT_W'($urandom_range(2, 300)), 1'b0);
    clock_now = time_t'($urandom);
    random_round(ROUND_ITEMS);

    configure(WAIT_W'($urandom_range(1, 65535)), 1'($urandom_range(1)));
    clock_now = time_t'($urandom);
    random_round(ROUND_ITEMS);

    settle();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d results from %0d add, %0d tick, %0d delete and %0d clear requests",
             checked, sent[CMD_ADD], sent[CMD_TICK], sent[CMD_DELETE], sent[CMD_CLEAR]);
    $display("Covered wait 1, 20, 65535 and random, drop and re-arm modes, a full %0d-entry table",
             CAPACITY);
    if (errors == 0) begin
      $display("connection_timeout_queue_unit test passed");
    end else begin
      $display("connection_timeout_queue_unit test failed");
    end
    $finish;
  end

endmodule
